// ===== src/himu_pkg.sv =====
`default_nettype none
package himu_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       block_start;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
        logic [25:0]        light_level;
        logic [8:0]         sample_index;
        logic               last_in_block;
        logic               bad_digit;
    } out_item_t;

    // One decoded sample handed from the character front end to the math back end.
    typedef struct packed {
        logic [11:0] raw_x;
        logic [11:0] raw_y;
        logic [11:0] raw_z;
        logic [11:0] raw_light;
        logic [8:0]  sample_index;
        logic        last_in_block;
        logic        bad_digit;
    } sample_t;

    localparam logic [2:0] REG_GAIN_X   = 3'd0;
    localparam logic [2:0] REG_GAIN_Y   = 3'd1;
    localparam logic [2:0] REG_GAIN_Z   = 3'd2;
    localparam logic [2:0] REG_OFFSET_X = 3'd3;
    localparam logic [2:0] REG_OFFSET_Y = 3'd4;
    localparam logic [2:0] REG_OFFSET_Z = 3'd5;
    localparam logic [2:0] REG_LUX      = 3'd6;
    localparam logic [2:0] REG_VOLTS    = 3'd7;

    localparam logic [4:0] HEX_NONE = 5'd16;

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        begin
            d = HEX_NONE;
            if (c >= 8'h30 && c <= 8'h39) d = 5'(c - 8'h30);
            else if (c >= 8'h61 && c <= 8'h66) d = 5'(c - 8'h57);
            else if (c >= 8'h41 && c <= 8'h46) d = 5'(c - 8'h37);
            return d;
        end
    endfunction

endpackage
`default_nettype wire

// ===== src/himu_front.sv =====
`default_nettype none
module himu_front #(
    parameter int SAMPLES_PER_BLOCK = 300
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire himu_pkg::in_item_t in_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output himu_pkg::sample_t       smp_data,
    output logic                    smp_valid,
    input  wire logic               smp_ready
);
    import himu_pkg::*;

    localparam int CW = $clog2(SAMPLES_PER_BLOCK + 1);

    logic [3:0]    pos_reg, pos_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [11:0]   fv_reg [4];
    logic [11:0]   fv_next [4];
    logic [3:0]    fs_reg, fs_next;
    logic          err_reg, err_next;
    logic          sv_reg;
    sample_t       sd_reg;

    logic [3:0]    p;
    logic [1:0]    f;
    logic [4:0]    d;
    logic          fire, last;

    assign in_ready  = !sv_reg || smp_ready;
    assign fire      = in_valid && in_ready;
    assign smp_valid = sv_reg;
    assign smp_data  = sd_reg;

    always_comb
    begin
        p = in_data.block_start ? 4'd0 : pos_reg;
        cnt_next = in_data.block_start ? '0 : cnt_reg;
        if (p >= 4'd9) f = 2'd3;
        else if (p >= 4'd6) f = 2'd2;
        else if (p >= 4'd3) f = 2'd1;
        else f = 2'd0;
        fv_next = fv_reg;
        fs_next = fs_reg;
        err_next = (p == 4'd0) ? 1'b0 : err_reg;
        if (p == 4'd0 || p == 4'd3 || p == 4'd6 || p == 4'd9)
        begin
            fv_next[f] = '0;
            fs_next[f] = 1'b0;
        end
        d = hex_digit(in_data.char_code);
        if (!fs_next[f])
        begin
            if (d != HEX_NONE) fv_next[f] = {fv_next[f][7:0], d[3:0]};
            else
            begin
                fs_next[f] = 1'b1;
                err_next = 1'b1;
            end
        end
        last = (32'(cnt_next) + 32'd1 >= 32'(SAMPLES_PER_BLOCK));
        pos_next = (p == 4'd11) ? 4'd0 : p + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            cnt_reg <= '0;
            fs_reg  <= '0;
            err_reg <= 1'b0;
            sv_reg  <= 1'b0;
            for (int i = 0; i < 4; i++) fv_reg[i] <= '0;
        end
        else
        begin
            if (fire && p == 4'd11) sv_reg <= 1'b1;
            else if (smp_ready) sv_reg <= 1'b0;
            if (fire)
            begin
                pos_reg <= pos_next;
                fv_reg  <= fv_next;
                fs_reg  <= fs_next;
                err_reg <= err_next;
                if (p == 4'd11) cnt_reg <= last ? '0 : cnt_next + CW'(1);
                else cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && p == 4'd11)
        begin
            sd_reg.raw_x         <= fv_next[0];
            sd_reg.raw_y         <= fv_next[1];
            sd_reg.raw_z         <= fv_next[2];
            sd_reg.raw_light     <= fv_next[3];
            sd_reg.sample_index  <= 9'(cnt_next);
            sd_reg.last_in_block <= last;
            sd_reg.bad_digit     <= err_next;
        end
    end
endmodule
`default_nettype wire

// ===== src/himu_fifo.sv =====
`default_nettype none
module himu_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire himu_pkg::sample_t wr_data,
    input  wire logic              wr_valid,
    output logic                   wr_ready,
    output himu_pkg::sample_t      rd_data,
    output logic                   rd_valid,
    input  wire logic              rd_ready
);
    import himu_pkg::*;

    sample_t    mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= wr_data;
    end
endmodule
`default_nettype wire

// ===== src/himu_back.sv =====
`default_nettype none
module himu_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [15:0]       cfg_data,
    input  wire himu_pkg::sample_t smp_data,
    input  wire logic              smp_valid,
    output logic                   smp_ready,
    output himu_pkg::out_item_t    out_data,
    output logic                   out_valid,
    input  wire logic              out_ready
);
    import himu_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    logic [15:0]        gain_reg [3];
    logic signed [15:0] off_reg [3];
    logic [15:0]        lux_reg, volts_reg;

    state_t             st_reg;
    sample_t            s_reg;
    logic [1:0]         ch_reg;
    logic [5:0]         bit_reg;
    logic [44:0]        num_reg;
    logic [15:0]        den_reg;
    logic [16:0]        rem_reg;
    logic               neg_reg;
    logic signed [31:0] acc_reg [3];
    logic [25:0]        light_reg;
    logic               ov_v;
    out_item_t          o_reg;
    logic               ov_valid_reg;

    logic signed [19:0] prod;
    logic signed [32:0] scaled;
    logic [31:0]        mag;
    logic [27:0]        lprod;
    logic [16:0]        rem_sh;
    logic [16:0]        rem_sub;
    logic               qbit;
    logic [15:0]        gsel;
    logic signed [15:0] osel;
    logic [11:0]        rsel;
    logic [44:0]        qfull;
    logic signed [31:0] sat;

    assign smp_ready = st_reg == ST_IDLE;
    assign out_valid = ov_valid_reg;
    assign out_data  = o_reg;

    always_comb
    begin
        gsel = 16'd1;
        osel = '0;
        rsel = '0;
        case (ch_reg)
            2'd0: begin gsel = gain_reg[0]; osel = off_reg[0]; rsel = s_reg.raw_x; end
            2'd1: begin gsel = gain_reg[1]; osel = off_reg[1]; rsel = s_reg.raw_y; end
            2'd2: begin gsel = gain_reg[2]; osel = off_reg[2]; rsel = s_reg.raw_z; end
            default: begin gsel = volts_reg; osel = '0; rsel = s_reg.raw_light; end
        endcase
        if (gsel == 16'd0) gsel = 16'd1;
        prod   = 20'(signed'(rsel)) * 20'sd100;
        scaled = 33'(prod - 20'(osel)) <<< 12;
        mag    = scaled[32] ? 32'(-scaled) : 32'(scaled);
        lprod  = 28'({2'b0, rsel[11:2]} * lux_reg);
        rem_sh = {rem_reg[15:0], num_reg[44]};
        rem_sub = rem_sh - {1'b0, den_reg};
        qbit   = !rem_sub[16];
        qfull  = {num_reg[43:0], qbit};
        ov_v   = neg_reg ? (qfull > 45'h80000000) : (qfull > 45'h7FFFFFFF);
        if (ov_v) sat = neg_reg ? 32'sh80000000 : 32'sh7FFFFFFF;
        else sat = neg_reg ? -signed'(qfull[31:0]) : signed'(qfull[31:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                gain_reg[i] <= 16'd1;
                off_reg[i]  <= '0;
            end
            lux_reg      <= '0;
            volts_reg    <= 16'd1;
            st_reg       <= ST_IDLE;
            ov_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GAIN_X:   gain_reg[0] <= cfg_data;
                    REG_GAIN_Y:   gain_reg[1] <= cfg_data;
                    REG_GAIN_Z:   gain_reg[2] <= cfg_data;
                    REG_OFFSET_X: off_reg[0]  <= cfg_data;
                    REG_OFFSET_Y: off_reg[1]  <= cfg_data;
                    REG_OFFSET_Z: off_reg[2]  <= cfg_data;
                    REG_LUX:      lux_reg     <= cfg_data;
                    REG_VOLTS:    volts_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (st_reg == ST_DONE && (!ov_valid_reg || out_ready)) ov_valid_reg <= 1'b1;
            else if (out_ready) ov_valid_reg <= 1'b0;
            case (st_reg)
                ST_IDLE: if (smp_valid) st_reg <= ST_LOAD;
                ST_LOAD: st_reg <= ST_DIV;
                ST_DIV:  if (bit_reg == 6'd44 && ch_reg == 2'd3) st_reg <= ST_DONE;
                         else if (bit_reg == 6'd44) st_reg <= ST_LOAD;
                ST_DONE: if (!ov_valid_reg || out_ready) st_reg <= ST_IDLE;
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            ST_IDLE:
            begin
                s_reg  <= smp_data;
                ch_reg <= 2'd0;
            end
            ST_LOAD:
            begin
                bit_reg <= '0;
                rem_reg <= '0;
                den_reg <= gsel;
                if (ch_reg == 2'd3)
                begin
                    num_reg <= 45'(lprod);
                    neg_reg <= 1'b0;
                end
                else
                begin
                    num_reg <= 45'(mag);
                    neg_reg <= scaled[32];
                end
            end
            ST_DIV:
            begin
                rem_reg <= qbit ? rem_sub : rem_sh;
                num_reg <= qfull;
                bit_reg <= bit_reg + 6'd1;
                if (bit_reg == 6'd44)
                begin
                    if (ch_reg == 2'd3) light_reg <= qfull[25:0];
                    else acc_reg[ch_reg] <= sat;
                    ch_reg <= ch_reg + 2'd1;
                end
            end
            ST_DONE:
            begin
                if (!ov_valid_reg || out_ready)
                begin
                    o_reg.accel_x       <= acc_reg[0];
                    o_reg.accel_y       <= acc_reg[1];
                    o_reg.accel_z       <= acc_reg[2];
                    o_reg.light_level   <= light_reg;
                    o_reg.sample_index  <= s_reg.sample_index;
                    o_reg.last_in_block <= s_reg.last_in_block;
                    o_reg.bad_digit     <= s_reg.bad_digit;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== src/hex_imu_record_decoder.sv =====
`default_nettype none
// The back end works on one sample at a time, running a 45-step restoring divider once for
// each of the four fields; it takes no new sample from the queue until the result is loaded
// into the output register. Characters flow at one per cycle while a two-entry queue and the
// front register hold samples for the divider; once they are full the input stalls until
// the queue frees an entry. Reset (rst_n, asynchronous, active low) clears counters, fields,
// queue pointers and valid flags, and sets the configuration registers to their defaults.
module hex_imu_record_decoder #(
    parameter int SAMPLES_PER_BLOCK = 300
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [15:0]         cfg_data,
    input  wire himu_pkg::in_item_t  in_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output himu_pkg::out_item_t      out_data,
    output logic                     out_valid,
    input  wire logic                out_ready
);
    import himu_pkg::*;

    sample_t f_data, q_data;
    logic    f_valid, f_ready, q_valid, q_ready;

    himu_front #(.SAMPLES_PER_BLOCK(SAMPLES_PER_BLOCK)) u_front (
        .clk, .rst_n, .in_data, .in_valid, .in_ready,
        .smp_data(f_data), .smp_valid(f_valid), .smp_ready(f_ready)
    );

    himu_fifo u_fifo (
        .clk, .rst_n,
        .wr_data(f_data), .wr_valid(f_valid), .wr_ready(f_ready),
        .rd_data(q_data), .rd_valid(q_valid), .rd_ready(q_ready)
    );

    himu_back u_back (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
        .smp_data(q_data), .smp_valid(q_valid), .smp_ready(q_ready),
        .out_data, .out_valid, .out_ready
    );
endmodule
`default_nettype wire

// ===== tb/hex_imu_record_decoder_tb.sv =====
module hex_imu_record_decoder_tb;
    import himu_pkg::*;

    localparam int SAMPLES = 300;
    localparam int IDLE_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = REG_GAIN_X;
    logic [15:0] cfg_data = '0;
    in_item_t in_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    out_item_t out_data;
    logic out_valid;
    logic out_ready = 1'b0;

    hex_imu_record_decoder #(.SAMPLES_PER_BLOCK(SAMPLES)) u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_data(in_data), .in_valid(in_valid),
        .in_ready(in_ready), .out_data(out_data), .out_valid(out_valid),
        .out_ready(out_ready)
    );

    always #5 clk = ~clk;

    logic [15:0] gain [3];
    logic signed [15:0] offset [3];
    logic [15:0] lux_reg;
    logic [15:0] volts_reg;

    logic [3:0] char_pos;
    int unsigned sample_cnt;
    logic [11:0] field_val [4];
    logic field_stop [4];
    logic digit_err;

    out_item_t samples_due[$];
    int error_count = 0;
    int idle_cycles = 0;
    int out_wait = 0;

    function automatic logic [31:0] scale_axis(logic [11:0] raw, logic signed [15:0] off,
                                               logic [15:0] g);
        longint r;
        longint q;
        longint d;
        r = raw > 12'd2047 ? longint'(raw) - 4096 : longint'(raw);
        d = g == 0 ? 1 : longint'(g);
        q = ((r * 100 - longint'(off)) * 4096) / d;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q[31:0];
    endfunction

    function automatic int hex_value(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return 16;
    endfunction

    task automatic decode_char(in_item_t it);
        int f;
        int d;
        longint unsigned lt;
        longint unsigned v;
        out_item_t o;
        if (it.block_start)
        begin
            char_pos = 0;
            sample_cnt = 0;
        end
        if (char_pos > 11) char_pos = 0;
        f = char_pos / 3;
        if (char_pos % 3 == 0)
        begin
            field_val[f] = 0;
            field_stop[f] = 0;
        end
        if (char_pos == 0) digit_err = 0;
        if (!field_stop[f])
        begin
            d = hex_value(it.char_code);
            if (d < 16) field_val[f] = {field_val[f][7:0], 4'(d)};
            else
            begin
                field_stop[f] = 1;
                digit_err = 1;
            end
        end
        if (char_pos < 11)
        begin
            char_pos++;
            return;
        end
        char_pos = 0;
        v = volts_reg == 0 ? 1 : volts_reg;
        lt = (longint'(field_val[3] >> 2) * lux_reg) / v;
        o.accel_x = scale_axis(field_val[0], offset[0], gain[0]);
        o.accel_y = scale_axis(field_val[1], offset[1], gain[1]);
        o.accel_z = scale_axis(field_val[2], offset[2], gain[2]);
        o.light_level = lt[25:0];
        o.sample_index = sample_cnt[8:0];
        o.last_in_block = sample_cnt + 1 >= SAMPLES;
        o.bad_digit = digit_err;
        sample_cnt = o.last_in_block ? 0 : sample_cnt + 1;
        samples_due.push_back(o);
    endtask

    task automatic send_char(logic [7:0] c, logic bs);
        int gap;
        in_item_t it;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.char_code = c;
        it.block_start = bs;
        in_data <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        decode_char(it);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_GAIN_X: gain[0] = val;
            REG_GAIN_Y: gain[1] = val;
            REG_GAIN_Z: gain[2] = val;
            REG_OFFSET_X: offset[0] = val;
            REG_OFFSET_Y: offset[1] = val;
            REG_OFFSET_Z: offset[2] = val;
            REG_LUX: lux_reg = val;
            REG_VOLTS: volts_reg = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (samples_due.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic logic [7:0] hex_char(int d);
        if (d < 10) return 8'("0" + d);
        return $urandom_range(0, 1) ? 8'("a" + d - 10) : 8'("A" + d - 10);
    endfunction

    function automatic logic [7:0] noise_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (hex_value(c) < 16);
        return c;
    endfunction

    task automatic send_field(logic [11:0] v);
        send_char(hex_char(v[11:8]), 1'b0);
        send_char(hex_char(v[7:4]), 1'b0);
        send_char(hex_char(v[3:0]), 1'b0);
    endtask

    task automatic test_directed();
        send_char("7", 1'b1);
        send_char("F", 1'b0);
        send_char("f", 1'b0);
        send_field(12'h800);
        send_field(12'hfff);
        send_field(12'hfff);
        send_char("0", 1'b0);
        send_char("x", 1'b0);
        send_char("9", 1'b0);
        send_char("-", 1'b0);
        send_char("A", 1'b0);
        send_char("1", 1'b0);
        send_field(12'h001);
        send_char(8'hff, 1'b0);
        send_char(8'h00, 1'b0);
        send_char("5", 1'b0);
        drain();
    endtask

    task automatic test_config(bit extreme);
        write_reg(REG_GAIN_X, extreme ? 16'd1 : 16'($urandom_range(0, 65535)));
        write_reg(REG_GAIN_Y, extreme ? 16'hffff : 16'($urandom_range(0, 300)));
        write_reg(REG_GAIN_Z, extreme ? 16'd0 : 16'($urandom_range(1, 65535)));
        write_reg(REG_OFFSET_X, extreme ? 16'h8000 : 16'($urandom));
        write_reg(REG_OFFSET_Y, extreme ? 16'h7fff : 16'($urandom));
        write_reg(REG_OFFSET_Z, 16'($urandom));
        write_reg(REG_LUX, extreme ? 16'hffff : 16'($urandom));
        write_reg(REG_VOLTS, extreme ? 16'd1 : 16'($urandom_range(0, 65535)));
        cfg_we <= 1'b0;
    endtask

    task automatic test_random(int n);
        for (int s = 0; s < n; s++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_char(8'($urandom), 1'($urandom));
            end
            else
            begin
                for (int k = 0; k < 12; k++)
                begin
                    logic [7:0] c;
                    c = $urandom_range(0, 19) == 0 ? noise_char()
                                                  : hex_char($urandom_range(0, 15));
                    send_char(c, (s == 0 && k == 0) || $urandom_range(0, 999) == 0);
                end
            end
        end
        drain();
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("hex_imu_record_decoder_tb: done, errors");
                $finish;
            end
            if (out_valid && out_ready)
            begin
                if (samples_due.size() == 0)
                begin
                    $error("unexpected transaction %p", out_data);
                    error_count++;
                end
                else
                begin
                    out_item_t e;
                    e = samples_due.pop_front();
                    if (out_data.accel_x !== e.accel_x)
                    begin
                        $error("accel_x exp %0d got %0d", e.accel_x, out_data.accel_x);
                        error_count++;
                    end
                    if (out_data.accel_y !== e.accel_y)
                    begin
                        $error("accel_y exp %0d got %0d", e.accel_y, out_data.accel_y);
                        error_count++;
                    end
                    if (out_data.accel_z !== e.accel_z)
                    begin
                        $error("accel_z exp %0d got %0d", e.accel_z, out_data.accel_z);
                        error_count++;
                    end
                    if (out_data.light_level !== e.light_level)
                    begin
                        $error("light_level exp %0d got %0d", e.light_level,
                               out_data.light_level);
                        error_count++;
                    end
                    if (out_data.sample_index !== e.sample_index)
                    begin
                        $error("sample_index exp %0d got %0d", e.sample_index,
                               out_data.sample_index);
                        error_count++;
                    end
                    if (out_data.last_in_block !== e.last_in_block)
                    begin
                        $error("last_in_block exp %0b got %0b", e.last_in_block,
                               out_data.last_in_block);
                        error_count++;
                    end
                    if (out_data.bad_digit !== e.bad_digit)
                    begin
                        $error("bad_digit exp %0b got %0b", e.bad_digit, out_data.bad_digit);
                        error_count++;
                    end
                end
                out_wait = $urandom_range(0, 16);
            end
            else if (out_wait > 0) out_wait--;
            out_ready <= out_wait == 0;
        end
    end

    initial
    begin
        for (int i = 0; i < 3; i++)
        begin
            gain[i] = 1;
            offset[i] = 0;
        end
        lux_reg = 0;
        volts_reg = 1;
        char_pos = 0;
        sample_cnt = 0;
        digit_err = 0;
        for (int i = 0; i < 4; i++)
        begin
            field_val[i] = 0;
            field_stop[i] = 0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config(1'b1);
        test_directed();
        test_random(35);
        test_config(1'b0);
        test_random(35);
        test_config(1'b0);
        test_random(25);
        test_config(1'b1);
        test_random(25);
        if (error_count == 0)
            $display("hex_imu_record_decoder_tb: done, clean");
        else
            $display("hex_imu_record_decoder_tb: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/himu_pkg.sv
src/himu_front.sv
src/himu_fifo.sv
src/himu_back.sv
src/hex_imu_record_decoder.sv
tb/hex_imu_record_decoder_tb.sv
